// File: hw/rtl/icp_pkg.sv
// Shared types and constants of the intcode processor core.
package icp_pkg;

    localparam int MEM_DEPTH_DEF = 4096;
    localparam int STEP_LIMIT    = 65536;
    localparam int STEP_W        = $clog2(STEP_LIMIT + 1);

    localparam logic [3:0] MODE_POS = 4'd0;
    localparam logic [3:0] MODE_IMM = 4'd1;
    localparam logic [3:0] MODE_REL = 4'd2;

    localparam logic [1:0] ST_OUT   = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic       KIND_LOAD = 1'b0;
    localparam logic       KIND_RUN  = 1'b1;

    localparam logic [7:0] OP_HALT_BCD = 8'h99;

    typedef enum logic [3:0] {
        OP_ADD = 4'd1,
        OP_MUL = 4'd2,
        OP_IN  = 4'd3,
        OP_OUT = 4'd4,
        OP_JT  = 4'd5,
        OP_JF  = 4'd6,
        OP_LT  = 4'd7,
        OP_EQ  = 4'd8,
        OP_ARB = 4'd9
    } t_opcode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COPY,
        S_FETCH,
        S_WORD,
        S_DIGITS,
        S_DECODE,
        S_OPND,
        S_OPND_WAIT,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_MUL,
        S_MULWB,
        S_DONE
    } t_state;

endpackage

// File: hw/rtl/icp_in_if.sv
// Request channel of the intcode processor: load and run beats.
interface icp_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] address;
    logic signed [63:0] word;
    logic signed [63:0] coord_x;
    logic signed [63:0] coord_y;

    modport source (output valid, kind, address, word, coord_x, coord_y, input ready);
    modport sink   (input valid, kind, address, word, coord_x, coord_y, output ready);
endinterface

// File: hw/rtl/icp_out_if.sv
// Result channel of the intcode processor: one beat per run.
interface icp_out_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] value;
    logic [1:0]  status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// File: hw/rtl/intcode_processor_core.sv
// Intcode processor core: program image, working memory and instruction sequencer.
// After reset the program image is cleared entry by entry, during which no beat is
// taken. A run beat first copies the image into working memory, then executes one
// instruction at a time through the single read port of the working memory: fetch,
// decimal digit extraction (4 bits a cycle), decode, operand address resolution,
// operand reads and execute; a multiply adds partial-product steps on a shared 32x32
// multiplier. A result waits in an output register while the next beat is taken.
module intcode_processor_core #(
    parameter int MEM_DEPTH = icp_pkg::MEM_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    icp_in_if.sink    i_req,
    icp_out_if.source o_rsp
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int PW = AW + 1;
    localparam int LW = (AW > 12) ? AW : 12;
    localparam int SW = icp_pkg::STEP_W;

    icp_pkg::t_state  r_state, n_state;

    logic [63:0] img_mem  [MEM_DEPTH];
    logic [63:0] work_mem [MEM_DEPTH];
    logic [63:0] r_img_q, r_wm_q;

    logic [PW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_pc, n_pc;
    logic [63:0]   r_rb, n_rb;
    logic          r_first, n_first;
    logic [SW-1:0] r_steps, n_steps;
    logic [63:0]   r_x, n_x, r_y, n_y;
    logic [63:0]   r_word, n_word;
    logic [19:0]   r_bcd, n_bcd;
    logic [3:0]    r_dcnt, n_dcnt;
    icp_pkg::t_opcode r_op, n_op;
    logic [1:0]    r_nops, n_nops;
    logic          r_wr3, n_wr3;
    logic [1:0]    r_oi, n_oi;
    logic [AW-1:0] r_a0, n_a0, r_a1, n_a1, r_a2, n_a2;
    logic [63:0]   r_v1, n_v1, r_v2, n_v2;
    logic [63:0]   r_prod, n_prod, r_acc, n_acc;
    logic [1:0]    r_mcnt, n_mcnt;
    logic [63:0]   r_res_value, n_res_value;
    logic [1:0]    r_res_status, n_res_status;
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_value, n_out_value;
    logic [1:0]    r_out_status, n_out_status;

    // memory port controls
    logic          w_img_we;
    logic [AW-1:0] w_img_waddr, w_img_raddr;
    logic [63:0]   w_img_wdata;
    logic          w_wm_we;
    logic [AW-1:0] w_wm_waddr, w_wm_raddr;
    logic [63:0]   w_wm_wdata;

    // checks
    logic          w_accept;
    logic [LW-1:0] w_ld_addr;
    logic          w_ld_ok;
    logic [3:0]    w_md;
    logic          w_is_write;
    logic          w_last;
    logic [PW-1:0] w_slot;
    logic          w_slot_ok;
    logic [63:0]   w_ind;
    logic          w_ind_ok;
    logic          w_pc_ok;
    logic          w_op_ok;
    logic [1:0]    w_dec_nops;
    logic          w_dec_wr3;
    logic          w_take;
    logic          w_tgt_ok;
    logic          w_fin;
    logic [1:0]    w_fin_st;
    logic          w_slot_free;
    logic [31:0]   w_mul_a, w_mul_b;

    // one double-dabble step per bit; the carry out of the top digit is dropped,
    // which keeps the value modulo 100000
    function automatic logic [19:0] dabble4(input logic [19:0] bcd, input logic [3:0] bits);
        logic [19:0] b;
        b = bcd;
        for (int s = 3; s >= 0; s--) begin
            for (int d = 0; d < 5; d++) begin
                if (b[d*4 +: 4] >= 4'd5) begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[18:0], bits[s]};
        end
        return b;
    endfunction

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_ld_addr   = LW'(i_req.address);
    assign w_ld_ok     = {1'b0, w_ld_addr} < (LW+1)'(MEM_DEPTH);
    assign w_last      = (r_oi + 2'd1) == r_nops;
    assign w_is_write  = r_wr3 && w_last;
    assign w_slot      = r_pc + PW'(r_oi) + PW'(1);
    assign w_slot_ok   = w_slot < PW'(MEM_DEPTH);
    assign w_ind       = (w_md == icp_pkg::MODE_REL) ? (r_rb + r_wm_q) : r_wm_q;
    assign w_ind_ok    = w_ind < 64'(MEM_DEPTH);
    assign w_pc_ok     = r_pc < PW'(MEM_DEPTH);
    assign w_take      = (r_op == icp_pkg::OP_JT) == (r_v1 != 64'd0);
    assign w_tgt_ok    = r_v2 < 64'(MEM_DEPTH);
    assign w_slot_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        case (r_oi)
            2'd0:    w_md = r_bcd[11:8];
            2'd1:    w_md = r_bcd[15:12];
            default: w_md = r_bcd[19:16];
        endcase
    end

    // opcode classes from the two low decimal digits
    always_comb begin
        w_op_ok    = 1'b0;
        w_dec_nops = 2'd1;
        w_dec_wr3  = 1'b0;
        if (r_bcd[7:4] == 4'd0) begin
            case (r_bcd[3:0])
                4'd1, 4'd2, 4'd7, 4'd8: begin
                    w_op_ok = 1'b1; w_dec_nops = 2'd3; w_dec_wr3 = 1'b1;
                end
                4'd5, 4'd6: begin
                    w_op_ok = 1'b1; w_dec_nops = 2'd2;
                end
                4'd3: begin
                    w_op_ok = 1'b1; w_dec_wr3 = 1'b1;
                end
                4'd4, 4'd9: begin
                    w_op_ok = 1'b1;
                end
                default: w_op_ok = 1'b0;
            endcase
        end
    end

    // run termination and its status
    always_comb begin
        w_fin    = 1'b0;
        w_fin_st = icp_pkg::ST_HALT;
        case (r_state)
            icp_pkg::S_FETCH: begin
                if (r_steps == SW'(icp_pkg::STEP_LIMIT)) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_HALT;
                end else if (!w_pc_ok) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_RANGE;
                end
            end
            icp_pkg::S_WORD: begin
                if (r_wm_q[63]) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_BAD;
                end
            end
            icp_pkg::S_DECODE: begin
                if (r_bcd[7:0] == icp_pkg::OP_HALT_BCD) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_HALT;
                end else if (!w_op_ok) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_BAD;
                end
            end
            icp_pkg::S_OPND: begin
                if (w_md > icp_pkg::MODE_REL || (w_md == icp_pkg::MODE_IMM && w_is_write)) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_BAD;
                end else if (!w_slot_ok) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_RANGE;
                end
            end
            icp_pkg::S_OPND_WAIT: begin
                if (!w_ind_ok) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_RANGE;
                end
            end
            icp_pkg::S_EXEC: begin
                if (r_op == icp_pkg::OP_OUT) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_OUT;
                end else if ((r_op == icp_pkg::OP_JT || r_op == icp_pkg::OP_JF)
                             && w_take && !w_tgt_ok) begin
                    w_fin = 1'b1; w_fin_st = icp_pkg::ST_RANGE;
                end
            end
            default: w_fin = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            icp_pkg::S_CLEAR:
                if (r_cnt == PW'(MEM_DEPTH - 1)) n_state = icp_pkg::S_IDLE;
            icp_pkg::S_IDLE:
                if (w_accept && i_req.kind == icp_pkg::KIND_RUN) n_state = icp_pkg::S_COPY;
            icp_pkg::S_COPY:
                if (r_cnt == PW'(MEM_DEPTH)) n_state = icp_pkg::S_FETCH;
            icp_pkg::S_FETCH:
                n_state = w_fin ? icp_pkg::S_DONE : icp_pkg::S_WORD;
            icp_pkg::S_WORD:
                n_state = w_fin ? icp_pkg::S_DONE : icp_pkg::S_DIGITS;
            icp_pkg::S_DIGITS:
                if (r_dcnt == 4'd15) n_state = icp_pkg::S_DECODE;
            icp_pkg::S_DECODE:
                n_state = w_fin ? icp_pkg::S_DONE : icp_pkg::S_OPND;
            icp_pkg::S_OPND: begin
                if (w_fin) begin
                    n_state = icp_pkg::S_DONE;
                end else if (w_md != icp_pkg::MODE_IMM) begin
                    n_state = icp_pkg::S_OPND_WAIT;
                end else if (w_last) begin
                    n_state = icp_pkg::S_RD1;
                end
            end
            icp_pkg::S_OPND_WAIT: begin
                if (w_fin)       n_state = icp_pkg::S_DONE;
                else if (w_last) n_state = icp_pkg::S_RD1;
                else             n_state = icp_pkg::S_OPND;
            end
            icp_pkg::S_RD1:
                n_state = icp_pkg::S_RD2;
            icp_pkg::S_RD2: begin
                // first visit lands v1; a second visit is made for opcodes with more than one operand
                if (r_mcnt == 2'd0 && r_nops != 2'd1) n_state = icp_pkg::S_RD2;
                else                                 n_state = icp_pkg::S_EXEC;
            end
            icp_pkg::S_EXEC: begin
                if (w_fin)                        n_state = icp_pkg::S_DONE;
                else if (r_op == icp_pkg::OP_MUL) n_state = icp_pkg::S_MUL;
                else                              n_state = icp_pkg::S_FETCH;
            end
            icp_pkg::S_MUL:
                if (r_mcnt == 2'd3) n_state = icp_pkg::S_MULWB;
            icp_pkg::S_MULWB:
                n_state = icp_pkg::S_FETCH;
            icp_pkg::S_DONE:
                if (w_slot_free) n_state = icp_pkg::S_IDLE;
            default:
                n_state = icp_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cnt        = r_cnt;
        n_pc         = r_pc;
        n_rb         = r_rb;
        n_first      = r_first;
        n_steps      = r_steps;
        n_x          = r_x;
        n_y          = r_y;
        n_word       = r_word;
        n_bcd        = r_bcd;
        n_dcnt       = r_dcnt;
        n_op         = r_op;
        n_nops       = r_nops;
        n_wr3        = r_wr3;
        n_oi         = r_oi;
        n_a0         = r_a0;
        n_a1         = r_a1;
        n_a2         = r_a2;
        n_v1         = r_v1;
        n_v2         = r_v2;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_mcnt       = r_mcnt;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        w_img_we    = 1'b0;
        w_img_waddr = w_ld_addr[AW-1:0];
        w_img_wdata = i_req.word;
        w_img_raddr = r_cnt[AW-1:0];
        w_wm_we     = 1'b0;
        w_wm_waddr  = r_a2;
        w_wm_wdata  = r_acc;
        w_wm_raddr  = r_pc[AW-1:0];
        w_mul_a     = r_v1[31:0];
        w_mul_b     = r_v2[31:0];

        if (o_rsp.valid && o_rsp.ready) n_out_valid = 1'b0;

        if (w_fin) begin
            n_res_status = w_fin_st;
            n_res_value  = (w_fin_st == icp_pkg::ST_OUT) ? r_v1 : '1;
        end

        case (r_state)
            icp_pkg::S_CLEAR: begin
                w_img_we    = 1'b1;
                w_img_waddr = r_cnt[AW-1:0];
                w_img_wdata = '0;
                n_cnt       = r_cnt + PW'(1);
            end
            icp_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_req.kind == icp_pkg::KIND_LOAD) begin
                        w_img_we = w_ld_ok;
                    end else begin
                        n_cnt   = '0;
                        n_pc    = '0;
                        n_rb    = '0;
                        n_first = 1'b0;
                        n_steps = '0;
                        n_x     = i_req.coord_x;
                        n_y     = i_req.coord_y;
                    end
                end
            end
            icp_pkg::S_COPY: begin
                // read image entry cnt, write the entry read in the previous cycle to working memory
                w_wm_we    = r_cnt != '0;
                w_wm_waddr = AW'(r_cnt - PW'(1));
                w_wm_wdata = r_img_q;
                n_cnt      = r_cnt + PW'(1);
            end
            icp_pkg::S_FETCH: begin
                w_wm_raddr = r_pc[AW-1:0];
            end
            icp_pkg::S_WORD: begin
                n_word = r_wm_q;
                n_bcd  = '0;
                n_dcnt = '0;
            end
            icp_pkg::S_DIGITS: begin
                n_bcd  = dabble4(r_bcd, r_word[63:60]);
                n_word = {r_word[59:0], 4'd0};
                n_dcnt = r_dcnt + 4'd1;
            end
            icp_pkg::S_DECODE: begin
                n_op   = icp_pkg::t_opcode'(r_bcd[3:0]);
                n_nops = w_dec_nops;
                n_wr3  = w_dec_wr3;
                n_oi   = '0;
            end
            icp_pkg::S_OPND: begin
                w_wm_raddr = w_slot[AW-1:0];
                if (!w_fin && w_md == icp_pkg::MODE_IMM) begin
                    case (r_oi)
                        2'd0:    n_a0 = w_slot[AW-1:0];
                        2'd1:    n_a1 = w_slot[AW-1:0];
                        default: n_a2 = w_slot[AW-1:0];
                    endcase
                    if (!w_last) n_oi = r_oi + 2'd1;
                end
            end
            icp_pkg::S_OPND_WAIT: begin
                case (r_oi)
                    2'd0:    n_a0 = w_ind[AW-1:0];
                    2'd1:    n_a1 = w_ind[AW-1:0];
                    default: n_a2 = w_ind[AW-1:0];
                endcase
                if (!w_last) n_oi = r_oi + 2'd1;
            end
            icp_pkg::S_RD1: begin
                w_wm_raddr = r_a0;
                n_mcnt     = 2'd0;
            end
            icp_pkg::S_RD2: begin
                w_wm_raddr = r_a1;
                if (r_mcnt == 2'd0) begin
                    n_v1   = r_wm_q;
                    n_mcnt = 2'd1;
                end else begin
                    n_v2 = r_wm_q;
                end
            end
            icp_pkg::S_EXEC: begin
                n_mcnt = 2'd0;
                case (r_op)
                    icp_pkg::OP_ADD: begin
                        w_wm_we    = 1'b1;
                        w_wm_wdata = r_v1 + r_v2;
                        n_pc       = r_pc + PW'(4);
                    end
                    icp_pkg::OP_LT: begin
                        w_wm_we    = 1'b1;
                        w_wm_wdata = ($signed(r_v1) < $signed(r_v2)) ? 64'd1 : 64'd0;
                        n_pc       = r_pc + PW'(4);
                    end
                    icp_pkg::OP_EQ: begin
                        w_wm_we    = 1'b1;
                        w_wm_wdata = (r_v1 == r_v2) ? 64'd1 : 64'd0;
                        n_pc       = r_pc + PW'(4);
                    end
                    icp_pkg::OP_IN: begin
                        w_wm_we    = 1'b1;
                        w_wm_waddr = r_a0;
                        w_wm_wdata = r_first ? r_y : r_x;
                        n_first    = 1'b1;
                        n_pc       = r_pc + PW'(2);
                    end
                    icp_pkg::OP_JT, icp_pkg::OP_JF: begin
                        n_pc = w_take ? r_v2[PW-1:0] : r_pc + PW'(3);
                    end
                    icp_pkg::OP_ARB: begin
                        n_rb = r_rb + r_v1;
                        n_pc = r_pc + PW'(2);
                    end
                    default: n_pc = r_pc;
                endcase
                if (r_op != icp_pkg::OP_MUL) n_steps = r_steps + SW'(1);
            end
            icp_pkg::S_MUL: begin
                // low 64 bits: aL*bL + ((aL*bH + aH*bL) << 32), one partial product a cycle
                case (r_mcnt)
                    2'd0: begin
                        w_mul_a = r_v1[31:0];  w_mul_b = r_v2[31:0];
                    end
                    2'd1: begin
                        w_mul_a = r_v1[31:0];  w_mul_b = r_v2[63:32];
                    end
                    default: begin
                        w_mul_a = r_v1[63:32]; w_mul_b = r_v2[31:0];
                    end
                endcase
                n_prod = 64'(w_mul_a) * 64'(w_mul_b);
                case (r_mcnt)
                    2'd0:    n_acc = r_acc;
                    2'd1:    n_acc = r_prod;
                    default: n_acc = r_acc + {r_prod[31:0], 32'd0};
                endcase
                n_mcnt = r_mcnt + 2'd1;
            end
            icp_pkg::S_MULWB: begin
                w_wm_we    = 1'b1;
                w_wm_wdata = r_acc;
                n_pc       = r_pc + PW'(4);
                n_steps    = r_steps + SW'(1);
            end
            icp_pkg::S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_status = r_res_status;
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_img_we) begin
            img_mem[w_img_waddr] <= w_img_wdata;
        end
        r_img_q <= img_mem[w_img_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wm_we) begin
            work_mem[w_wm_waddr] <= w_wm_wdata;
        end
        r_wm_q <= work_mem[w_wm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= icp_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc         <= n_pc;
        r_rb         <= n_rb;
        r_first      <= n_first;
        r_steps      <= n_steps;
        r_x          <= n_x;
        r_y          <= n_y;
        r_word       <= n_word;
        r_bcd        <= n_bcd;
        r_dcnt       <= n_dcnt;
        r_op         <= n_op;
        r_nops       <= n_nops;
        r_wr3        <= n_wr3;
        r_oi         <= n_oi;
        r_a0         <= n_a0;
        r_a1         <= n_a1;
        r_a2         <= n_a2;
        r_v1         <= n_v1;
        r_v2         <= n_v2;
        r_prod       <= n_prod;
        r_acc        <= n_acc;
        r_mcnt       <= n_mcnt;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign i_req.ready  = (r_state == icp_pkg::S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.value  = r_out_value;
    assign o_rsp.status = r_out_status;

endmodule
